>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define AFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define AFS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/afs_pkg.sv
// Package for the audio frame sequencer: opcodes, sequence points, status bits.
`default_nettype none
package afs_pkg;

  typedef logic [1:0]  opcode_t;
  typedef logic [15:0] count_t;

  localparam opcode_t OP_TICK  = 2'd0;
  localparam opcode_t OP_WRITE = 2'd1;
  localparam opcode_t OP_READ  = 2'd2;

  localparam count_t STEP1_COUNT = 16'd7457;
  localparam count_t STEP2_COUNT = 16'd14913;
  localparam count_t STEP3_COUNT = 16'd22371;
  localparam count_t STEP4_COUNT = 16'd29828;
  localparam count_t STEP5_COUNT = 16'd37281;

  localparam int MODE_BIT       = 7;
  localparam int INHIBIT_BIT    = 6;
  localparam int IRQ_STATUS_BIT = 6;

endpackage
`default_nettype wire

>>> rtl/afs_if.sv
// Valid/ready channel interfaces for the sequencer's input and result words.
`default_nettype none
interface afs_in_if;
  logic                 valid;
  logic                 ready;
  afs_pkg::opcode_t     opcode;
  logic [7:0]           write_data;
  logic [4:0]           channel_active;

  modport source (output valid, output opcode, output write_data, output channel_active,
                  input ready);
  modport sink   (input valid, input opcode, input write_data, input channel_active,
                  output ready);
endinterface

interface afs_out_if;
  logic       valid;
  logic       ready;
  logic       pulse_timer_tick;
  logic       quarter_frame;
  logic       half_frame;
  logic       irq_line;
  logic [7:0] read_data;

  modport source (output valid, output pulse_timer_tick, output quarter_frame,
                  output half_frame, output irq_line, output read_data, input ready);
  modport sink   (input valid, input pulse_timer_tick, input quarter_frame,
                  input half_frame, input irq_line, input read_data, output ready);
endinterface
`default_nettype wire

>>> rtl/audio_frame_sequencer.sv
// Audio frame sequencer: pulse-timer enable, frame strobes, frame IRQ and status.
// Usage:
//   in_chan  takes one word per handshake: a CPU-cycle tick, a frame-control
//            write (bit7 five-step mode, bit6 IRQ inhibit) or a status read.
//   out_chan returns exactly one result word per input word, in order:
//            pulse-timer enable, quarter/half frame strobes, the frame IRQ
//            flag after the word, and the status byte on reads (else 0).
// Pipeline: the input register, then the sequencer logic feeding the result
//   register.
// Throughput: one word per cycle unless stalled; the sequence state updates in
//   the single cycle where a word moves from input register to result register.
// Stall: while out_chan.ready is low the result holds, the input register
//   still takes one more word, then in_chan.ready drops until the result
//   is taken.
// Reset (rst_n low, synchronous): both stages empty, four-step mode, count 0,
//   IRQ flag, inhibit and half-rate phase cleared.
`default_nettype none
module audio_frame_sequencer (
  input  wire logic clk,
  input  wire logic rst_n,
  afs_in_if.sink    in_chan,
  afs_out_if.source out_chan
);
  import afs_pkg::*;

  // input register
  logic       s1_valid_r;
  opcode_t    s1_opcode_r;
  logic [7:0] s1_data_r;
  logic [4:0] s1_chans_r;

  // sequencer state
  count_t cycle_count_r,   cycle_count_nxt;
  logic   five_step_r,     five_step_nxt;
  logic   inhibit_r,       inhibit_nxt;
  logic   irq_pending_r,   irq_pending_nxt;
  logic   phase_r,         phase_nxt;

  // result register
  logic       out_valid_r;
  logic       ptick_r, qf_r, hf_r, irq_r;
  logic [7:0] rd_r;
  logic       ptick_nxt, qf_nxt, hf_nxt;
  logic [7:0] rd_nxt;

  logic   in_acc;
  logic   adv;
  count_t cnt_inc;

  assign adv           = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || adv;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign cnt_inc       = cycle_count_r + 16'd1;

  always_comb begin
    cycle_count_nxt = cycle_count_r;
    five_step_nxt   = five_step_r;
    inhibit_nxt     = inhibit_r;
    irq_pending_nxt = irq_pending_r;
    phase_nxt       = phase_r;
    ptick_nxt       = 1'b0;
    qf_nxt          = 1'b0;
    hf_nxt          = 1'b0;
    rd_nxt          = 8'd0;
    if (adv) begin
      unique case (s1_opcode_r)
        OP_TICK: begin
          phase_nxt       = !phase_r;
          ptick_nxt       = !phase_r;
          cycle_count_nxt = cnt_inc;
          if (cnt_inc == STEP1_COUNT || cnt_inc == STEP3_COUNT) begin
            qf_nxt = 1'b1;
          end
          if (cnt_inc == STEP2_COUNT) begin
            qf_nxt = 1'b1;
            hf_nxt = 1'b1;
          end
          if (!five_step_r && cnt_inc == STEP4_COUNT) begin
            qf_nxt          = 1'b1;
            hf_nxt          = 1'b1;
            cycle_count_nxt = '0;
            if (!inhibit_r) irq_pending_nxt = 1'b1;
          end
          if (five_step_r && cnt_inc == STEP5_COUNT) begin
            qf_nxt          = 1'b1;
            hf_nxt          = 1'b1;
            cycle_count_nxt = '0;
          end
        end
        OP_WRITE: begin
          cycle_count_nxt = '0;
          five_step_nxt   = s1_data_r[MODE_BIT];
          inhibit_nxt     = s1_data_r[INHIBIT_BIT];
          irq_pending_nxt = 1'b0;
          qf_nxt          = s1_data_r[MODE_BIT];
          hf_nxt          = s1_data_r[MODE_BIT];
        end
        OP_READ: begin
          rd_nxt                 = {3'b000, s1_chans_r};
          rd_nxt[IRQ_STATUS_BIT] = irq_pending_r;
          irq_pending_nxt        = 1'b0;
        end
        default: begin
          // unused opcode: state holds, result carries only the flag
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      cycle_count_r <= '0;
      five_step_r   <= 1'b0;
      inhibit_r     <= 1'b0;
      irq_pending_r <= 1'b0;
      phase_r       <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      cycle_count_r <= cycle_count_nxt;
      five_step_r   <= five_step_nxt;
      inhibit_r     <= inhibit_nxt;
      irq_pending_r <= irq_pending_nxt;
      phase_r       <= phase_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_opcode_r <= in_chan.opcode;
      s1_data_r   <= in_chan.write_data;
      s1_chans_r  <= in_chan.channel_active;
    end
    if (adv) begin
      ptick_r <= ptick_nxt;
      qf_r    <= qf_nxt;
      hf_r    <= hf_nxt;
      irq_r   <= irq_pending_nxt;
      rd_r    <= rd_nxt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.pulse_timer_tick = ptick_r;
  assign out_chan.quarter_frame    = qf_r;
  assign out_chan.half_frame       = hf_r;
  assign out_chan.irq_line         = irq_r;
  assign out_chan.read_data        = rd_r;

endmodule
`default_nettype wire

>>> rtl/afs_checker.sv
// Port-level checker for the audio frame sequencer and its bind.
`default_nettype none
`include "assert_macros.svh"
module afs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_pulse_timer_tick,
  input wire logic       out_quarter_frame,
  input wire logic       out_half_frame,
  input wire logic       out_irq_line,
  input wire logic [7:0] out_read_data
);

  // a stalled result word is not withdrawn
  `AFS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  // every half-frame point is also a quarter-frame point
  `AFS_ASSERT(a_half_has_quarter, out_valid && out_half_frame |-> out_quarter_frame, "half strobe without quarter strobe")
  // a nonzero status byte comes only from a read, which clears the flag and strobes nothing
  `AFS_ASSERT(a_read_word, out_valid && out_read_data != 8'd0 |-> !out_irq_line && !out_pulse_timer_tick && !out_quarter_frame && !out_read_data[7] && !out_read_data[5], "bad status word")
  // reset empties the result stage
  `AFS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind audio_frame_sequencer afs_checker u_afs_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_chan.valid),
  .out_ready            (out_chan.ready),
  .out_pulse_timer_tick (out_chan.pulse_timer_tick),
  .out_quarter_frame    (out_chan.quarter_frame),
  .out_half_frame       (out_chan.half_frame),
  .out_irq_line         (out_chan.irq_line),
  .out_read_data        (out_chan.read_data)
);
`default_nettype wire
